[hdl/sha5_pkg.sv]
package sha5_pkg;

  typedef logic [63:0] word_t;

  // One schedule word on its way from the front end to the compression core.
  typedef struct packed {
    word_t data;
    logic  last_blk;
  } qword_t;

  localparam word_t HashInit [0:7] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam int unsigned NumRounds = 80;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  // Round constants, one per round.
  function automatic word_t round_const(input logic [6:0] idx);
    word_t k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

[hdl/sha512_hash_engine.sv]
// SHA-512 over a byte stream. Each input word carries at most one message byte
// (byte_valid) and may close the message (end_of_message); an item with neither flag
// set does nothing. The front end takes one byte per cycle while full is low and packs
// eight bytes into a schedule word, which waits in a small queue for the compression
// core. The core loads 16 words, then runs the 80 rounds one per cycle and updates the
// hash. The queue holds four words, so during a compression the input takes 32 bytes
// and then stalls. Closing a message holds the input while the padding and length
// words go out: 3 to 16 words when the last block has room for the length, 17 or 18
// words when a second block is needed, and that case also waits out a full
// compression. The final compression then runs while bytes of the next message fill
// the queue. The eight digest words come out most significant word first with
// word_index 0 to 7 and last_word on the eighth; the next message is compressed once
// the eighth word is popped.
module sha512_hash_engine #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha5_pkg::*;

  qword_t f_data;
  qword_t c_data;
  logic   f_push;
  logic   f_full;
  logic   c_pop;
  logic   c_empty;

  sha5_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .q_push         (f_push),
    .q_data         (f_data),
    .q_full         (f_full)
  );

  sha5_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_data),
    .full    (f_full),
    .rd      (c_pop),
    .rd_data (c_data),
    .empty   (c_empty)
  );

  sha5_core u_core (
    .clk         (clk),
    .rst         (rst),
    .q_data      (c_data),
    .q_empty     (c_empty),
    .q_pop       (c_pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

[hdl/sha5_front.sv]
module sha5_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte,
  input  logic             byte_valid,
  input  logic             end_of_message,
  output logic             q_push,
  output sha5_pkg::qword_t q_data,
  input  logic             q_full
);
  import sha5_pkg::*;

  localparam logic [2:0] F_DATA  = 3'd0;
  localparam logic [2:0] F_MARK  = 3'd1;
  localparam logic [2:0] F_ZERO  = 3'd2;
  localparam logic [2:0] F_LENHI = 3'd3;
  localparam logic [2:0] F_LENLO = 3'd4;

  logic [2:0]   state;
  logic [63:0]  acc;
  logic [2:0]   pos;
  logic [3:0]   word_cnt;
  logic [124:0] byte_cnt;
  logic         accept;
  logic [63:0]  mark_tmp;
  logic [63:0]  mark_word;

  assign full   = (state != F_DATA) || q_full;
  assign accept = push && !full;

  // The end marker byte follows the buffered bytes; later bytes of the word are zero.
  assign mark_tmp  = {acc[55:0], 8'h80};
  assign mark_word = mark_tmp << {3'(3'd7 - pos), 3'b000};

  // Word toward the core.
  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    case (state)
      F_DATA: begin
        if (accept && byte_valid && pos == 3'd7) begin
          q_push      = 1'b1;
          q_data.data = {acc[55:0], data_byte};
        end
      end
      F_MARK: begin
        q_push      = !q_full;
        q_data.data = mark_word;
      end
      F_ZERO: begin
        q_push = !q_full;
      end
      F_LENHI: begin
        q_push      = !q_full;
        q_data.data = byte_cnt[124:61];
      end
      F_LENLO: begin
        q_push          = !q_full;
        q_data.data     = {byte_cnt[60:0], 3'b000};
        q_data.last_blk = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Byte packing and padding sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_DATA;
      pos      <= '0;
      word_cnt <= '0;
      byte_cnt <= '0;
    end else begin
      case (state)
        F_DATA: begin
          if (accept) begin
            if (byte_valid) begin
              acc      <= {acc[55:0], data_byte};
              pos      <= pos + 3'd1;
              byte_cnt <= byte_cnt + 125'd1;
              if (pos == 3'd7) begin
                word_cnt <= word_cnt + 4'd1;
              end
            end
            if (end_of_message) begin
              state <= F_MARK;
            end
          end
        end
        F_MARK: begin
          if (!q_full) begin
            word_cnt <= word_cnt + 4'd1;
            state    <= (word_cnt == 4'd13) ? F_LENHI : F_ZERO;
          end
        end
        F_ZERO: begin
          if (!q_full) begin
            word_cnt <= word_cnt + 4'd1;
            if (word_cnt == 4'd13) begin
              state <= F_LENHI;
            end
          end
        end
        F_LENHI: begin
          if (!q_full) begin
            word_cnt <= word_cnt + 4'd1;
            state    <= F_LENLO;
          end
        end
        F_LENLO: begin
          if (!q_full) begin
            word_cnt <= '0;
            pos      <= '0;
            byte_cnt <= '0;
            state    <= F_DATA;
          end
        end
        default: begin
          state <= F_DATA;
        end
      endcase
    end
  end

endmodule

[hdl/sha5_fifo.sv]
module sha5_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sha5_pkg::qword_t wr_data,
  output logic             full,
  input  logic             rd,
  output sha5_pkg::qword_t rd_data,
  output logic             empty
);
  import sha5_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  qword_t            mem [0:DEPTH-1];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[hdl/sha5_core.sv]
module sha5_core (
  input  logic             clk,
  input  logic             rst,
  input  sha5_pkg::qword_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic [63:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic             empty,
  input  logic             pop
);
  import sha5_pkg::*;

  localparam logic [1:0] B_LOAD  = 2'd0;
  localparam logic [1:0] B_ROUND = 2'd1;
  localparam logic [1:0] B_ADD   = 2'd2;
  localparam logic [1:0] B_OUT   = 2'd3;

  logic [1:0] state;
  word_t      w  [0:15];
  word_t      v  [0:7];
  word_t      hw [0:7];
  logic [3:0] load_cnt;
  logic [6:0] rnd;
  logic [2:0] out_idx;
  logic       last_blk;
  word_t      t1;
  word_t      t2;
  word_t      ch;
  word_t      maj;
  word_t      w_new;

  assign q_pop       = (state == B_LOAD) && !q_empty;
  assign empty       = (state != B_OUT);
  assign digest_word = hw[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == 3'd7);

  // One round and one schedule word per cycle.
  always_comb begin
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + big_sigma1(v[4]) + ch + round_const(rnd) + w[0];
    t2    = big_sigma0(v[0]) + maj;
    w_new = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
  end

  // Schedule window: words enter at the top and leave from the bottom.
  always_ff @(posedge clk) begin
    if (q_pop || state == B_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= q_pop ? q_data.data : w_new;
    end
    if (q_pop) begin
      last_blk <= q_data.last_blk;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (state == B_LOAD && q_pop && load_cnt == 4'd15) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hw[i];
      end
    end else if (state == B_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Block sequencing, hash update and digest readout.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_LOAD;
      load_cnt <= '0;
      rnd      <= '0;
      out_idx  <= '0;
      for (int i = 0; i < 8; i++) begin
        hw[i] <= HashInit[i];
      end
    end else begin
      case (state)
        B_LOAD: begin
          if (q_pop) begin
            load_cnt <= load_cnt + 4'd1;
            if (load_cnt == 4'd15) begin
              rnd   <= '0;
              state <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'(NumRounds - 1)) begin
            state <= B_ADD;
          end
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hw[i] <= hw[i] + v[i];
          end
          out_idx <= '0;
          state   <= last_blk ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (pop) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hw[i] <= HashInit[i];
              end
              state <= B_LOAD;
            end
          end
        end
        default: begin
          state <= B_LOAD;
        end
      endcase
    end
  end

endmodule

[verif/sha512_digest_checker.sv]
// Watches both channels of the hash engine, predicts digests and compares them.
module sha512_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words
);
  import sha5_pkg::*;

  typedef struct packed {
    word_t      digest;
    logic [2:0] index;
    logic       last;
  } digest_entry_t;

  word_t          chain_hash [0:7];
  logic [7:0]     msg_block [0:127];
  int unsigned    bytes_held;
  logic [127:0]   bits_done;
  digest_entry_t  digest_queue [$];

  // Rotate right by n bits.
  function automatic word_t ror64(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Round constants, taken as a table from the package.
  function automatic word_t k_const(input int i);
    return round_const(7'(i));
  endfunction

  // One 80-round compression of the current block into the chaining words.
  task automatic compress_block();
    word_t w [0:79];
    word_t v [0:7];
    word_t t1, t2, e, a;
    for (int i = 0; i < 16; i++) begin
      w[i] = '0;
      for (int j = 0; j < 8; j++) w[i] = (w[i] << 8) | word_t'(msg_block[i*8+j]);
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
           + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int i = 0; i < 80; i++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
         + ((e & v[5]) ^ (~e & v[6])) + k_const(i) + w[i];
      t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain_hash[i] = HashInit[i];
    bits_done = '0;
    bytes_held = 0;
  endtask

  // Absorb one accepted word; on the end mark, pad and queue the digest.
  task automatic absorb_word(input logic [7:0] b, input logic bv, input logic eom);
    logic [127:0] total_bits;
    int pos;
    if (bv) begin
      msg_block[bytes_held] = b;
      bytes_held++;
      if (bytes_held == 128) begin
        compress_block();
        bits_done += 128'd1024;
        bytes_held = 0;
      end
    end
    if (eom) begin
      total_bits = bits_done + 128'(bytes_held * 8);
      pos = bytes_held;
      msg_block[pos++] = 8'h80;
      if (pos > 112) begin
        while (pos < 128) msg_block[pos++] = 8'h00;
        compress_block();
        pos = 0;
      end
      while (pos < 112) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 16; i++) msg_block[112+i] = total_bits[127-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        digest_queue.push_back(digest_entry_t'{chain_hash[i], 3'(i), i == 7});
      restart_message();
    end
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    digest_entry_t want;
    if (rst) begin
      restart_message();
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (pop && !empty) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                   digest_word, word_index, last_word);
          fail_count++;
        end else begin
          want = digest_queue.pop_front();
          if (want.digest !== digest_word || want.index !== word_index ||
              want.last !== last_word) begin
            $display("%0t: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                     $time, want.digest, want.index, want.last,
                     digest_word, word_index, last_word);
            fail_count++;
          end
        end
      end
      if (push && !full) absorb_word(data_byte, byte_valid, end_of_message);
    end
    pending_words = digest_queue.size();
  end
endmodule

[verif/tb_top.sv]
module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;
  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;

  always #10 clk = ~clk;

  sha512_hash_engine DUT (.*);

  sha512_digest_checker checker_i (.*);

  // Receiver: random stalls at the current rate.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
  end

  // Send one word and wait until it is taken; push stays up for the next word.
  task automatic send_word(input logic [7:0] b, input logic bv, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    byte_valid <= bv;
    end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // A message of the given length with random or fixed bytes, closed by the last byte
  // or by an empty end word, with idle words sprinkled in.
  task automatic send_message(input int len, input bit fixed_byte, input logic [7:0] fb);
    bit empty_end;
    empty_end = (len == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(fixed_byte ? fb : 8'($urandom), 1'b1, !empty_end && i == len - 1);
    end
    if (empty_end) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop sending and wait until every predicted digest word has been popped.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  initial begin
    int lens [$];
    int words;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, idle words, extreme bytes, padding edges.
    send_word(8'hff, 1'b0, 1'b0);
    send_message(0, 1'b0, 8'h00);
    send_message(1, 1'b1, 8'h00);
    send_message(1, 1'b1, 8'hff);
    send_message(3, 1'b0, 8'h00);
    drain();
    lens = '{111, 112, 128};
    foreach (lens[i]) send_message(lens[i], 1'b0, 8'h00);
    drain();

    // Random messages across the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 22 : 45) : 0;
      pop_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 22 : 45) : 0;
      words = 0;
      while (words < 10) begin
        case ($urandom_range(3))
          0: lens = '{$urandom_range(8)};
          1: lens = '{$urandom_range(12, 16)};
          default: lens = '{$urandom_range(10)};
        endcase
        send_message(lens[0], 1'b0, 8'h00);
        words += lens[0] + 1;
      end
      drain();
    end

    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
